// File: hw/rtl/spiram_pkg.sv
// Shared types and constants for the SPI register access master.
package spiram_pkg;

   localparam logic [7:0] READ_CMD_BITS  = 8'hC0;
   localparam logic [7:0] WRITE_CMD_BITS = 8'h00;
   localparam logic [7:0] DUMMY_BYTE     = 8'hFF;
   localparam logic [7:0] HALF_MAX       = 8'd128;
   localparam logic [7:0] HALF_MIN       = 8'd1;
   localparam logic [7:0] HALF_RESET     = 8'd32;

   localparam logic       REQ_WRITE = 1'b0;
   localparam logic       REQ_READ  = 1'b1;

   typedef struct packed {
      logic       miso_bit;
      logic [1:0] chip_index;
      logic [7:0] write_data;
      logic [5:0] reg_addr;
      logic       req_type;
      logic       req_valid;
   } item_type;

   typedef struct packed {
      logic [15:0] read_word;
      logic        done_res;
      logic        busy_res;
      logic [3:0]  cs_lines_n;
      logic        mosi_level;
      logic        sck_level;
   } result_type;

endpackage

// File: hw/rtl/spiram_engine.sv
// Transfer state and next-state logic for one system clock tick of the SPI master.
module spiram_engine #(
   parameter int NUM_SLAVES = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  spiram_pkg::item_type   item,
   input  logic [7:0]             half_period,
   output spiram_pkg::result_type result
);

   typedef enum logic [0:0] {
      PH_IDLE,
      PH_XFER
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [6:0] div_ff, div_in;
   logic [2:0] bit_ff, bit_in;
   logic [1:0] byte_ff, byte_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] low_ff, low_in;
   logic [7:0] high_ff, high_in;
   logic [1:0] chip_ff, chip_in;
   logic       type_ff, type_in;
   logic       sck_ff, sck_in;
   logic       samp_ff, samp_in;

   logic [7:0]  half_eff;
   logic [7:0]  div_next;
   logic        done;
   logic        busy;
   logic [15:0] word;
   logic [3:0]  cs_n;

   always_comb begin
      phase_in = phase_ff;
      div_in   = div_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      shift_in = shift_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      chip_in  = chip_ff;
      type_in  = type_ff;
      sck_in   = sck_ff;
      samp_in  = samp_ff;
      done     = 1'b0;
      word     = 16'd0;

      if (half_period == 8'd0) begin
         half_eff = spiram_pkg::HALF_MIN;
      end else if (half_period > spiram_pkg::HALF_MAX) begin
         half_eff = spiram_pkg::HALF_MAX;
      end else begin
         half_eff = half_period;
      end
      div_next = {1'b0, div_ff} + 8'd1;

      if (step) begin
         case (phase_ff)
            PH_IDLE: begin
               if (item.req_valid) begin
                  chip_in  = item.chip_index;
                  type_in  = item.req_type;
                  shift_in = ((item.req_type == spiram_pkg::REQ_READ) ?
                              spiram_pkg::READ_CMD_BITS : spiram_pkg::WRITE_CMD_BITS)
                             | {2'b00, item.reg_addr};
                  low_in   = item.write_data;
                  high_in  = 8'd0;
                  div_in   = 7'd0;
                  bit_in   = 3'd0;
                  byte_in  = 2'd0;
                  sck_in   = 1'b0;
                  phase_in = PH_XFER;
               end
            end
            PH_XFER: begin
               if (div_next >= half_eff) begin
                  div_in = 7'd0;
                  if (!sck_ff) begin
                     sck_in  = 1'b1;
                     samp_in = item.miso_bit;
                  end else begin
                     sck_in   = 1'b0;
                     shift_in = {shift_ff[6:0], samp_ff};
                     if (bit_ff == 3'd7) begin
                        bit_in = 3'd0;
                        if (type_ff == spiram_pkg::REQ_WRITE) begin
                           if (byte_ff == 2'd0) begin
                              shift_in = low_ff;
                              byte_in  = 2'd1;
                           end else begin
                              low_in  = {shift_ff[6:0], samp_ff};
                              high_in = 8'd0;
                              done    = 1'b1;
                           end
                        end else begin
                           if (byte_ff == 2'd0) begin
                              shift_in = spiram_pkg::DUMMY_BYTE;
                              byte_in  = 2'd1;
                           end else if (byte_ff == 2'd1) begin
                              low_in   = {shift_ff[6:0], samp_ff};
                              shift_in = spiram_pkg::DUMMY_BYTE;
                              byte_in  = 2'd2;
                           end else begin
                              high_in = {shift_ff[6:0], samp_ff};
                              done    = 1'b1;
                           end
                        end
                        if (done) begin
                           phase_in = PH_IDLE;
                           word     = {high_in, low_in};
                        end
                     end else begin
                        bit_in = bit_ff + 3'd1;
                     end
                  end
               end else begin
                  div_in = div_next[6:0];
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      busy = (phase_in == PH_XFER);
      cs_n = 4'hF;
      if (busy && (int'(chip_in) < NUM_SLAVES)) begin
         cs_n[chip_in] = 1'b0;
      end

      result.sck_level  = busy ? sck_in : 1'b0;
      result.mosi_level = busy ? shift_in[7] : 1'b0;
      result.cs_lines_n = cs_n;
      result.busy_res   = busy;
      result.done_res   = done;
      result.read_word  = word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         div_ff   <= 7'd0;
         bit_ff   <= 3'd0;
         byte_ff  <= 2'd0;
         shift_ff <= 8'd0;
         low_ff   <= 8'd0;
         high_ff  <= 8'd0;
         chip_ff  <= 2'd0;
         type_ff  <= 1'b0;
         sck_ff   <= 1'b0;
         samp_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         div_ff   <= div_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         chip_ff  <= chip_in;
         type_ff  <= type_in;
         sck_ff   <= sck_in;
         samp_ff  <= samp_in;
      end
   end

endmodule

// File: hw/rtl/spi_register_access_master_core.sv
// Top level of the SPI mode 0 register access master with stream ports.
// Each accepted input word is one system clock tick and yields one result word.
// The result is registered: it is in the output register the cycle after acceptance.
// Throughput is one word per cycle; a new word is accepted whenever the output register is empty
// or is read in the same cycle.
// Synchronous active-high reset idles the transfer engine and sets the half period to 32.
module spi_register_access_master_core #(
   parameter int NUM_SLAVES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: req_valid, reg_addr, write_data, chip_index, miso_bit, zero pad.
   input  logic [23:0] req_tdata,
   // Fields from bit 0: req_type.
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: sck_level, mosi_level, cs_lines_n, busy_res, done_res, read_word.
   output logic [23:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic                   step;
   logic [7:0]             half_ff;
   logic                   rsp_valid_ff;
   spiram_pkg::result_type rsp_ff;
   spiram_pkg::item_type   item;
   spiram_pkg::result_type result;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   assign item.req_valid  = req_tdata[0];
   assign item.req_type   = req_tuser;
   assign item.reg_addr   = req_tdata[6:1];
   assign item.write_data = req_tdata[14:7];
   assign item.chip_index = req_tdata[16:15];
   assign item.miso_bit   = req_tdata[17];

   spiram_engine #(
      .NUM_SLAVES(NUM_SLAVES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (item),
      .half_period (half_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff      <= spiram_pkg::HALF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            half_ff <= csr_wr_data;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res)
      else $error("Done reported while the transfer is still busy.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.done_res |-> rsp_ff.read_word == 16'd0)
      else $error("Read word is nonzero outside the done word.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.busy_res |->
         rsp_ff.cs_lines_n == 4'hF && !rsp_ff.sck_level && !rsp_ff.mosi_level)
      else $error("Bus lines are not idle while no transfer runs.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(~rsp_ff.cs_lines_n))
      else $error("More than one chip select is asserted.");

endmodule
